[rtl/core/mpc_pkg.sv]
// Shared types and constants of the modular power and congruence unit.
package mpc_pkg;

  localparam int unsigned WIDTH_DEF = 31;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MODE = '0;

  localparam logic MODE_POWER = 1'b0;
  localparam logic MODE_CONG  = 1'b1;

  typedef enum logic {
    OP_DIV,
    OP_MULMOD
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

endpackage

[rtl/core/mpc_stream_if.sv]
// Valid/ready channel interfaces for the item and result transfers.
interface mpc_in_if #(
  parameter int unsigned Width = 31
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] base;
  logic [Width-1:0] operand_b;
  logic [Width-1:0] modulus;

  modport source (output valid, output base, output operand_b, output modulus, input ready);
  modport sink   (input valid, input base, input operand_b, input modulus, output ready);
endinterface

interface mpc_out_if #(
  parameter int unsigned Width = 31
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] value;
  logic             no_solution;

  modport source (output valid, output value, output no_solution, input ready);
  modport sink   (input valid, input value, input no_solution, output ready);
endinterface

[rtl/core/modular_power_and_congruence_unit.sv]
// Top level: sequencer for modular power and linear congruence over a shared unit.
// Power mode runs a modular multiply for each set exponent bit and a modular square for
// every exponent bit; congruence mode runs one division per gcd step and a division and
// a multiply per inverse step. The next item is taken while a result waits.
// Reset is asynchronous and active low; it clears the sequencer and sets mode to power.
module modular_power_and_congruence_unit
  import mpc_pkg::*;
#(
  parameter int unsigned Width = WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mpc_in_if.sink             req_i,
  mpc_out_if.source          rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_P_RED, S_P_BIT, S_P_MUL, S_P_SQR,
    S_G_CHK, S_G_DIV, S_C_BMOD, S_C_A, S_C_M, S_C_AR,
    S_I_INIT, S_I_CHK, S_I_DIV, S_I_MS, S_I_MUL,
    S_F_B, S_F_MS, S_F_MUL, S_OUT
  } state_e;

  state_e           state_q;
  logic             cfg_mode;
  logic             mode_q;
  logic [Width-1:0] a_q, b_q, m_q;
  logic [Width-1:0] r0_q, r1_q, t0_q, t1_q, q_q;
  logic [Width-1:0] val_q;
  logic             nos_q;
  logic             out_valid_q;
  logic [Width-1:0] out_value_q;
  logic             out_nos_q;

  arith_req_t       unit_req;
  arith_rsp_t       unit_rsp;
  logic [Width-1:0] unit_a, unit_b, unit_m;
  logic [Width-1:0] unit_quot, unit_rem;

  logic [Width-1:0] q_adj, neg_p, t2;
  logic [Width:0]   t2_sum;

  mpc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (cfg_mode)
  );

  mpc_arith #(
    .Width (Width)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .opa_i  (unit_a),
    .opb_i  (unit_b),
    .mod_i  (unit_m),
    .rsp_o  (unit_rsp),
    .quot_o (unit_quot),
    .rem_o  (unit_rem)
  );

  always_comb begin
    q_adj  = (unit_quot == m_q) ? '0 : unit_quot;
    neg_p  = (unit_rem == '0) ? '0 : m_q - unit_rem;
    t2_sum = {1'b0, t0_q} + {1'b0, neg_p};
    t2     = (t2_sum >= {1'b0, m_q}) ? t2_sum[Width-1:0] - m_q : t2_sum[Width-1:0];
  end

  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = OP_DIV;
    unit_a         = '0;
    unit_b         = '0;
    unit_m         = m_q;
    case (state_q)
      S_START: begin
        if (mode_q == MODE_POWER && b_q != '0 && m_q != '0) begin
          unit_req.start = 1'b1;
          unit_a         = a_q;
          unit_b         = m_q;
        end
      end
      S_P_BIT: begin
        if (b_q != '0) begin
          unit_req.start = 1'b1;
          unit_req.op    = OP_MULMOD;
          unit_a         = b_q[0] ? t0_q : t1_q;
          unit_b         = t1_q;
        end
      end
      S_P_MUL: begin
        if (unit_rsp.done) begin
          unit_req.start = 1'b1;
          unit_req.op    = OP_MULMOD;
          unit_a         = t1_q;
          unit_b         = t1_q;
        end
      end
      S_G_CHK: begin
        unit_req.start = 1'b1;
        unit_a         = (r1_q == '0) ? b_q : r0_q;
        unit_b         = (r1_q == '0) ? r0_q : r1_q;
      end
      S_C_BMOD: begin
        if (unit_rsp.done && unit_rem == '0) begin
          unit_req.start = 1'b1;
          unit_a         = a_q;
          unit_b         = r0_q;
        end
      end
      S_C_A: begin
        if (unit_rsp.done) begin
          unit_req.start = 1'b1;
          unit_a         = m_q;
          unit_b         = r0_q;
        end
      end
      S_C_AR: begin
        unit_req.start = 1'b1;
        unit_a         = a_q;
        unit_b         = m_q;
      end
      S_I_CHK: begin
        unit_req.start = 1'b1;
        unit_a         = (r1_q == '0) ? b_q : r0_q;
        unit_b         = (r1_q == '0) ? m_q : r1_q;
      end
      S_I_MS: begin
        unit_req.start = 1'b1;
        unit_req.op    = OP_MULMOD;
        unit_a         = q_q;
        unit_b         = t1_q;
      end
      S_F_MS: begin
        unit_req.start = 1'b1;
        unit_req.op    = OP_MULMOD;
        unit_a         = q_q;
        unit_b         = t0_q;
      end
      default: begin
        unit_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_POWER;
      a_q         <= '0;
      b_q         <= '0;
      m_q         <= '0;
      r0_q        <= '0;
      r1_q        <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      q_q         <= '0;
      val_q       <= '0;
      nos_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_nos_q   <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            a_q     <= req_i.base;
            b_q     <= req_i.operand_b;
            m_q     <= req_i.modulus;
            mode_q  <= cfg_mode;
            val_q   <= '0;
            nos_q   <= 1'b0;
            state_q <= S_START;
          end
        end
        S_START: begin
          if (mode_q == MODE_POWER) begin
            if (b_q == '0) begin
              val_q   <= Width'(1);
              state_q <= S_OUT;
            end else if (m_q == '0) begin
              state_q <= S_OUT;
            end else begin
              t0_q    <= (m_q == Width'(1)) ? '0 : Width'(1);
              state_q <= S_P_RED;
            end
          end else if (m_q == '0) begin
            nos_q   <= 1'b1;
            state_q <= S_OUT;
          end else begin
            r0_q    <= a_q;
            r1_q    <= m_q;
            state_q <= S_G_CHK;
          end
        end
        S_P_RED: begin
          if (unit_rsp.done) begin
            t1_q    <= unit_rem;
            state_q <= S_P_BIT;
          end
        end
        S_P_BIT: begin
          if (b_q == '0) begin
            val_q   <= t0_q;
            state_q <= S_OUT;
          end else begin
            state_q <= b_q[0] ? S_P_MUL : S_P_SQR;
          end
        end
        S_P_MUL: begin
          if (unit_rsp.done) begin
            t0_q    <= unit_rem;
            state_q <= S_P_SQR;
          end
        end
        S_P_SQR: begin
          if (unit_rsp.done) begin
            t1_q    <= unit_rem;
            b_q     <= b_q >> 1;
            state_q <= S_P_BIT;
          end
        end
        S_G_CHK: begin
          state_q <= (r1_q == '0) ? S_C_BMOD : S_G_DIV;
        end
        S_G_DIV: begin
          if (unit_rsp.done) begin
            r0_q    <= r1_q;
            r1_q    <= unit_rem;
            state_q <= S_G_CHK;
          end
        end
        S_C_BMOD: begin
          if (unit_rsp.done) begin
            if (unit_rem != '0) begin
              nos_q   <= 1'b1;
              state_q <= S_OUT;
            end else begin
              b_q     <= unit_quot;
              state_q <= S_C_A;
            end
          end
        end
        S_C_A: begin
          if (unit_rsp.done) begin
            a_q     <= unit_quot;
            state_q <= S_C_M;
          end
        end
        S_C_M: begin
          if (unit_rsp.done) begin
            m_q     <= unit_quot;
            state_q <= S_C_AR;
          end
        end
        S_C_AR: begin
          state_q <= S_I_INIT;
        end
        S_I_INIT: begin
          if (unit_rsp.done) begin
            r0_q    <= m_q;
            r1_q    <= unit_rem;
            t0_q    <= '0;
            t1_q    <= (m_q == Width'(1)) ? '0 : Width'(1);
            state_q <= S_I_CHK;
          end
        end
        S_I_CHK: begin
          state_q <= (r1_q == '0) ? S_F_B : S_I_DIV;
        end
        S_I_DIV: begin
          if (unit_rsp.done) begin
            q_q     <= q_adj;
            r0_q    <= r1_q;
            r1_q    <= unit_rem;
            state_q <= S_I_MS;
          end
        end
        S_I_MS: begin
          state_q <= S_I_MUL;
        end
        S_I_MUL: begin
          if (unit_rsp.done) begin
            t0_q    <= t1_q;
            t1_q    <= t2;
            state_q <= S_I_CHK;
          end
        end
        S_F_B: begin
          if (unit_rsp.done) begin
            q_q     <= unit_rem;
            state_q <= S_F_MS;
          end
        end
        S_F_MS: begin
          state_q <= S_F_MUL;
        end
        S_F_MUL: begin
          if (unit_rsp.done) begin
            val_q   <= unit_rem;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_value_q <= val_q;
            out_nos_q   <= nos_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.value       = out_value_q;
  assign rsp_o.no_solution = out_nos_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_req.start |-> !unit_rsp.busy)
    else $error("Shared unit started while busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("Item taken while the previous one is still in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.no_solution) |-> (rsp_o.value == '0))
    else $error("Result without solution carries a nonzero value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_rsp.done |-> !unit_rsp.busy)
    else $error("Shared unit reports done while still busy.");
`endif

endmodule

[rtl/core/mpc_arith.sv]
// Shared bit-serial unit for restoring division and shift-and-add modular multiplication.
module mpc_arith
  import mpc_pkg::*;
#(
  parameter int unsigned Width = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arith_req_t       req_i,
  input  logic [Width-1:0] opa_i,
  input  logic [Width-1:0] opb_i,
  input  logic [Width-1:0] mod_i,
  output arith_rsp_t       rsp_o,
  output logic [Width-1:0] quot_o,
  output logic [Width-1:0] rem_o
);

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;

  logic            busy_q, done_q;
  arith_op_e       op_q;
  logic [CntW-1:0] cnt_q;
  logic [Width-1:0] acc_q, acc_d;
  logic [Width-1:0] shf_q, shf_d;
  logic [Width-1:0] x_q;
  logic [Width-1:0] m_q;

  logic [Width:0]   div_trial, div_diff;
  logic             div_ge;
  logic [Width:0]   dbl, dbl_red, sum, sum_red;
  logic [Width-1:0] addend;

  always_comb begin
    div_trial = {acc_q, shf_q[Width-1]};
    div_diff  = div_trial - {1'b0, x_q};
    div_ge    = div_trial >= {1'b0, x_q};
    dbl       = {acc_q, 1'b0};
    dbl_red   = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    addend    = shf_q[Width-1] ? x_q : '0;
    sum       = dbl_red + {1'b0, addend};
    sum_red   = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
    acc_d     = acc_q;
    shf_d     = shf_q;
    if (req_i.start && !busy_q) begin
      acc_d = '0;
      shf_d = (req_i.op == OP_DIV) ? opa_i : opb_i;
    end else if (busy_q) begin
      case (op_q)
        OP_DIV: begin
          acc_d = div_ge ? div_diff[Width-1:0] : div_trial[Width-1:0];
          shf_d = {shf_q[Width-2:0], div_ge};
        end
        OP_MULMOD: begin
          acc_d = sum_red[Width-1:0];
          shf_d = {shf_q[Width-2:0], 1'b0};
        end
        default: begin
          acc_d = acc_q;
          shf_d = shf_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= CntW'(Width - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    shf_q <= shf_d;
    if (req_i.start && !busy_q) begin
      x_q <= (req_i.op == OP_DIV) ? opb_i : opa_i;
      m_q <= mod_i;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = shf_q;
  assign rem_o      = acc_q;

endmodule

[rtl/core/mpc_apb_regs.sv]
// APB-style configuration register holding the operating mode.
module mpc_apb_regs
  import mpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               mode_o
);

  logic                 mode_q;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_POWER;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODE) begin
      prdata = {31'b0, mode_q};
    end
  end

  assign mode_o = mode_q;

endmodule
